### hdl/no_wait_flow_shop_makespan_core_macros.svh
// ----------------------------------------------------------------------------
// no_wait_flow_shop_makespan_core_macros.svh
// Assertion macros shared by the flow-shop timing core.
// ----------------------------------------------------------------------------
`ifndef NO_WAIT_FLOW_SHOP_MAKESPAN_CORE_MACROS_SVH
`define NO_WAIT_FLOW_SHOP_MAKESPAN_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define NWFS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nwfs assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define NWFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nwfs assertion failed");

`endif

### hdl/nwfs_pkg.sv
// ----------------------------------------------------------------------------
// nwfs_pkg
// Types and constants for the no-wait flow-shop timing core.
// ----------------------------------------------------------------------------
package nwfs_pkg;

  localparam int MAX_STATIONS_DEF = 64;
  localparam int CNT_W   = 13;  // holds a station count up to 8191
  localparam int CFG_W   = 7;
  localparam int IDX_W   = 6;
  localparam int AMT_W   = 16;
  localparam int PROD_W  = 32;
  localparam int TIME_W  = 48;
  localparam int ACC_W   = 49;  // stored time plus the sum of all products

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_JOB  = 1'b1;

  // Token that walks down the row of cells.
  typedef struct packed {
    logic              valid;
    logic              pass2;   // 0: sums and shift, 1: write back
    logic [ACC_W-1:0]  acc;
    logic [TIME_W-1:0] shift;
    logic              ovf;
    logic [TIME_W-1:0] result;
  } token_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic             load;
    logic [IDX_W-1:0] load_idx;
    logic [AMT_W-1:0] amount;
    logic             prep;
    logic             clear;
    logic [CNT_W-1:0] n_eff;
  } cell_ctl_t;

endpackage

### hdl/nwfs_if.sv
// ----------------------------------------------------------------------------
// nwfs_if
// Valid/ready channels of the flow-shop timing core.
// ----------------------------------------------------------------------------
interface nwfs_req_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [nwfs_pkg::IDX_W-1:0] station_index;
  logic [nwfs_pkg::AMT_W-1:0] amount;
  logic                       new_batch;

  modport source (output valid, operation, station_index, amount, new_batch, input ready);
  modport sink   (input valid, operation, station_index, amount, new_batch, output ready);
endinterface

interface nwfs_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [nwfs_pkg::TIME_W-1:0] finish_time;
  logic                        saturated;

  modport source (output valid, finish_time, saturated, input ready);
  modport sink   (input valid, finish_time, saturated, output ready);
endinterface

interface nwfs_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [nwfs_pkg::CFG_W-1:0] station_count;

  modport source (output valid, station_count, input ready);
  modport sink   (input valid, station_count, output ready);
endinterface

### hdl/no_wait_flow_shop_makespan_core.sv
// ----------------------------------------------------------------------------
// no_wait_flow_shop_makespan_core
// No-wait flow-shop finish time over a row of station cells.
// ----------------------------------------------------------------------------
// A job runs as a token walk: every station is a cell in a row, and a token
// walks the whole row twice, one cell per cycle, first summing leave times and
// the largest shortfall against the previous job, then writing back the shifted,
// saturated finish times. The result waits in an output register; the next
// request is taken while it waits, but a finished job holds until it drains.
module no_wait_flow_shop_makespan_core #(
  parameter int MAX_STATIONS = nwfs_pkg::MAX_STATIONS_DEF
) (
  input logic        clk,
  input logic        rst,
  nwfs_req_if.sink   req,
  nwfs_rsp_if.source rsp,
  nwfs_cfg_if.sink   cfg
);

`include "no_wait_flow_shop_makespan_core_macros.svh"

  typedef enum logic [2:0] {
    IDLE, PREP, LAUNCH1, WAIT1, LAUNCH2, WAIT2, OUT
  } state_t;

  localparam logic [nwfs_pkg::CNT_W-1:0] MAX_N = nwfs_pkg::CNT_W'(MAX_STATIONS);

  state_t                      state;
  logic [nwfs_pkg::CFG_W-1:0]  count;
  logic [nwfs_pkg::AMT_W-1:0]  amt;
  logic                        nb;
  logic                        ovf_seen;
  logic [nwfs_pkg::TIME_W-1:0] shift;
  logic [nwfs_pkg::TIME_W-1:0] res_time;
  logic                        out_valid;
  logic [nwfs_pkg::TIME_W-1:0] out_time;
  logic                        out_sat;

  logic [nwfs_pkg::CNT_W-1:0]  cnt_ext;
  logic [nwfs_pkg::CNT_W-1:0]  n_eff;
  logic                        req_acc;
  logic                        out_load;
  nwfs_pkg::cell_ctl_t         ctl;
  nwfs_pkg::token_t            tok [0:MAX_STATIONS];
  logic [nwfs_pkg::TIME_W-1:0] finish0;
  logic [nwfs_pkg::TIME_W-1:0] finish_col [0:MAX_STATIONS-1];
  logic [MAX_STATIONS-1:0]     tok_valid;
  nwfs_pkg::token_t            tail;

  assign req.ready = (state == IDLE);
  assign cfg.ready = 1'b1;
  assign req_acc   = req.valid && req.ready;
  assign out_load  = (state == OUT) && (!out_valid || rsp.ready);

  assign cnt_ext = nwfs_pkg::CNT_W'(count);
  assign n_eff   = (count == '0)     ? nwfs_pkg::CNT_W'(1) :
                   (cnt_ext > MAX_N) ? MAX_N : cnt_ext;

  always_comb begin
    ctl.load     = req_acc && (req.operation == nwfs_pkg::OP_LOAD);
    ctl.load_idx = req.station_index;
    ctl.amount   = (state == PREP) ? amt : req.amount;
    ctl.prep     = (state == PREP);
    ctl.clear    = (state == PREP) && nb;
    ctl.n_eff    = n_eff;
  end

  // Inject the token at the head of the row.
  always_comb begin
    tok[0]        = '0;
    tok[0].valid  = (state == LAUNCH1) || (state == LAUNCH2);
    tok[0].pass2  = (state == LAUNCH2);
    tok[0].acc    = {1'b0, finish0};
    tok[0].shift  = (state == LAUNCH2) ? shift : '0;
    tok[0].ovf    = ovf_seen;
  end

  for (genvar j = 0; j < MAX_STATIONS; j++) begin : g_cell
    nwfs_cell #(.IDX(j)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .tok_in     (tok[j]),
      .tok_out    (tok[j+1]),
      .finish_out (finish_col[j])
    );
    assign tok_valid[j] = tok[j+1].valid;
  end

  assign finish0 = finish_col[0];
  assign tail    = tok[MAX_STATIONS];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= nwfs_pkg::CFG_W'(1);
      ovf_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        count <= cfg.station_count;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (req_acc && (req.operation == nwfs_pkg::OP_JOB)) begin
            amt <= req.amount;
            nb  <= req.new_batch;
            if (req.new_batch) begin
              ovf_seen <= 1'b0;
            end
            state <= PREP;
          end
        end
        PREP:    state <= LAUNCH1;
        LAUNCH1: state <= WAIT1;
        WAIT1: begin
          if (tail.valid) begin
            shift <= tail.shift;
            state <= LAUNCH2;
          end
        end
        LAUNCH2: state <= WAIT2;
        WAIT2: begin
          if (tail.valid) begin
            res_time <= tail.result;
            ovf_seen <= tail.ovf;
            state    <= OUT;
          end
        end
        OUT: begin
          // hold until the output register is free
          if (out_load) begin
            out_time <= res_time;
            out_sat  <= ovf_seen;
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.finish_time = out_time;
  assign rsp.saturated   = out_sat;

  `NWFS_ASSERT_NOW(a_one_token, 1'b1, $countones(tok_valid) <= 1)
  `NWFS_ASSERT_NOW(a_tail_in_walk, tail.valid, (state == WAIT1) || (state == WAIT2))
  `NWFS_ASSERT_NEXT(a_out_load, out_load, rsp.valid)

endmodule

### hdl/nwfs_cell.sv
// ----------------------------------------------------------------------------
// nwfs_cell
// One station: holds its speed and last finish time, updates the walking token.
// ----------------------------------------------------------------------------
module nwfs_cell #(
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  nwfs_pkg::cell_ctl_t         ctl,
  input  nwfs_pkg::token_t            tok_in,
  output nwfs_pkg::token_t            tok_out,
  output logic [nwfs_pkg::TIME_W-1:0] finish_out
);

  localparam logic [nwfs_pkg::CNT_W-1:0] POS = nwfs_pkg::CNT_W'(IDX);

  logic [nwfs_pkg::AMT_W-1:0]  speed;
  logic [nwfs_pkg::PROD_W-1:0] prod;
  logic [nwfs_pkg::TIME_W-1:0] finish;
  logic [nwfs_pkg::ACC_W-1:0]  times;

  logic                        en;
  logic                        is_last;
  logic                        ld_hit;
  logic [nwfs_pkg::ACC_W-1:0]  acc_sum;
  logic [nwfs_pkg::TIME_W-1:0] diff;
  logic                        behind;
  logic [nwfs_pkg::TIME_W+1:0] t_full;
  logic                        sat;
  logic [nwfs_pkg::TIME_W-1:0] t_sat;
  nwfs_pkg::token_t            tok_next;

  assign en      = POS < ctl.n_eff;
  assign is_last = POS == (ctl.n_eff - nwfs_pkg::CNT_W'(1));
  assign ld_hit  = POS == nwfs_pkg::CNT_W'(ctl.load_idx);

  assign acc_sum = tok_in.acc + nwfs_pkg::ACC_W'(prod);
  // shortfall of the incoming leave time against this station's last finish
  assign behind  = {1'b0, finish} > tok_in.acc;
  assign diff    = finish - tok_in.acc[nwfs_pkg::TIME_W-1:0];

  assign t_full = {1'b0, times} + {2'b00, tok_in.shift};
  assign sat    = |t_full[nwfs_pkg::TIME_W+1:nwfs_pkg::TIME_W];
  assign t_sat  = sat ? '1 : t_full[nwfs_pkg::TIME_W-1:0];

  always_comb begin
    tok_next = tok_in;
    if (tok_in.valid && !tok_in.pass2) begin
      tok_next.acc = acc_sum;
      if (en && behind && (diff > tok_in.shift)) begin
        tok_next.shift = diff;
      end
    end else if (tok_in.valid && en) begin
      tok_next.ovf = tok_in.ovf | sat;
      if (is_last) begin
        tok_next.result = t_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && ld_hit) begin
      speed <= ctl.amount;
    end
    if (ctl.prep) begin
      prod <= nwfs_pkg::PROD_W'(ctl.amount) * nwfs_pkg::PROD_W'(speed);
    end
    if (tok_in.valid && !tok_in.pass2) begin
      times <= acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      finish        <= '0;
      tok_out.valid <= 1'b0;
    end else begin
      if (ctl.clear) begin
        finish <= '0;
      end else if (tok_in.valid && tok_in.pass2 && en) begin
        finish <= t_sat;
      end
      tok_out <= tok_next;
    end
  end

  assign finish_out = finish;

endmodule
